### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock and active-low reset
`define MFS_ASSERT_CR(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset
`define MFS_ASSERT(lbl, prop, msg) \
  `MFS_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)

`endif

### hdl/mfs_pkg.sv
// ---------------------------------------------------------------------------
// mfs_pkg
// Types and constants shared by the maximum-frequency stack modules.
// ---------------------------------------------------------------------------
`default_nettype none

package mfs_pkg;

  // Number of entries held by the chain
  localparam int unsigned Depth = 64;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned ValW  = 32;

  typedef logic [IdxW-1:0]        idx_t;
  typedef logic [CntW-1:0]        cnt_t;
  typedef logic [CntW-1:0]        lvl_t;
  typedef logic signed [ValW-1:0] val_t;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // Scan token walking up the chain, one cell per cycle
  typedef struct packed {
    cnt_t       same;   // live entries equal to the operand
    logic [1:0] hits;   // entries at the maximum level, saturating at two
    idx_t       pos;    // newest entry at the maximum level
    logic       found;  // pos is valid
  } token_t;

  // Broadcast to every cell during a scan
  typedef struct packed {
    val_t value;
    cnt_t count;
    lvl_t max_level;
  } scan_t;

  // Broadcast to every cell on commit
  typedef struct packed {
    logic write;   // store value/level at wr_idx
    logic shift;   // cells at and above pos take their upper neighbour
    idx_t wr_idx;
    idx_t pos;
    val_t value;
    lvl_t level;
  } upd_t;

endpackage

`default_nettype wire

### hdl/mfs_cell.sv
// ---------------------------------------------------------------------------
// mfs_cell
// One stack entry: holds a value and its level, folds itself into the scan
// token and hands the token on, and shifts down on removal.
// ---------------------------------------------------------------------------
`default_nettype none

module mfs_cell import mfs_pkg::*; (
  input  logic   clk_i,
  input  idx_t   cell_idx_i,
  input  scan_t  scan_i,
  input  token_t tok_i,
  output token_t tok_o,
  input  upd_t   upd_i,
  input  val_t   next_value_i,
  input  lvl_t   next_level_i,
  output val_t   value_o,
  output lvl_t   level_o
);

  val_t   value_q, value_d;
  lvl_t   level_q, level_d;
  token_t tok_q, tok_d;
  logic   live;

  assign live = cnt_t'(cell_idx_i) < scan_i.count;

  // Fold this entry into the token
  always_comb begin
    tok_d = tok_i;
    if (live && (value_q == scan_i.value)) begin
      tok_d.same = tok_i.same + cnt_t'(1);
    end
    if (live && (level_q == scan_i.max_level)) begin
      tok_d.found = 1'b1;
      tok_d.pos   = cell_idx_i;
      if (tok_i.hits != 2'd2) begin
        tok_d.hits = tok_i.hits + 2'd1;
      end
    end
  end

  // Entry update: write on push, shift down on pop
  always_comb begin
    value_d = value_q;
    level_d = level_q;
    if (upd_i.write && (cell_idx_i == upd_i.wr_idx)) begin
      value_d = upd_i.value;
      level_d = upd_i.level;
    end else if (upd_i.shift && (cell_idx_i >= upd_i.pos)) begin
      value_d = next_value_i;
      level_d = next_level_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    level_q <= level_d;
    tok_q   <= tok_d;
  end

  assign tok_o   = tok_q;
  assign value_o = value_q;
  assign level_o = level_q;

endmodule

`default_nettype wire

### hdl/mfs_ctrl.sv
// ---------------------------------------------------------------------------
// mfs_ctrl
// Sequencer: takes the command, runs the scan over the live cells, commits
// the update and holds the result until it is transferred.
// ---------------------------------------------------------------------------
`default_nettype none

module mfs_ctrl import mfs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  logic    cmd_i,
  input  val_t    push_value_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output val_t    popped_value_o,
  output status_e status_o,
  input  token_t  tok_sel_i,
  input  val_t    pop_val_i,
  output scan_t   scan_o,
  output upd_t    upd_o,
  output idx_t    pos_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_APPLY = 3'b100
  } state_e;

  state_e  state_q, state_d;
  cnt_t    count_q, count_d;
  lvl_t    max_q, max_d;
  cnt_t    step_q, step_d;
  logic    cmd_q;
  val_t    opval_q;
  logic    out_valid_q, out_valid_d;
  val_t    out_val_q, out_val_d;
  status_e out_st_q, out_st_d;

  logic    accept;
  logic    commit;
  logic    is_push;
  lvl_t    new_lvl;
  idx_t    last_idx;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign commit   = (state_q == ST_APPLY) && (!out_valid_q || !out_stall_i);
  assign is_push  = (cmd_q == CMD_PUSH);
  assign last_idx = idx_t'(count_q - cnt_t'(1));
  assign new_lvl  = (count_q == '0) ? lvl_t'(1) : (tok_sel_i.same + lvl_t'(1));
  assign pos_o    = tok_sel_i.found ? tok_sel_i.pos : last_idx;

  // Command register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_i;
      opval_q <= push_value_i;
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    count_d     = count_q;
    max_d       = max_q;
    out_valid_d = out_valid_q;
    out_val_d   = out_val_q;
    out_st_d    = out_st_q;
    upd_o       = '0;
    upd_o.wr_idx = idx_t'(count_q);
    upd_o.pos   = pos_o;
    upd_o.value = opval_q;
    upd_o.level = new_lvl;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          step_d = '0;
          // Nothing to scan on an empty stack or a full push
          if ((count_q == '0) ||
              ((cmd_i == CMD_PUSH) && (count_q == cnt_t'(Depth)))) begin
            state_d = ST_APPLY;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Token has passed the newest live cell
        if (step_q == count_q - cnt_t'(1)) begin
          state_d = ST_APPLY;
        end else begin
          step_d = step_q + cnt_t'(1);
        end
      end
      ST_APPLY: begin
        if (commit) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          out_val_d   = '0;
          out_st_d    = STATUS_OK;
          if (is_push) begin
            if (count_q == cnt_t'(Depth)) begin
              out_st_d = STATUS_FULL;
            end else begin
              upd_o.write = 1'b1;
              count_d     = count_q + cnt_t'(1);
              if (new_lvl > max_q) begin
                max_d = new_lvl;
              end
            end
          end else begin
            if (count_q == '0) begin
              out_st_d = STATUS_EMPTY;
            end else begin
              out_val_d   = pop_val_i;
              upd_o.shift = 1'b1;
              count_d     = count_q - cnt_t'(1);
              // Level empties unless another entry sits at it
              if ((tok_sel_i.hits != 2'd2) && (max_q != '0)) begin
                max_d = max_q - lvl_t'(1);
              end
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      max_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      max_q       <= max_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    out_val_q <= out_val_d;
    out_st_q  <= out_st_d;
  end

  assign scan_o.value     = opval_q;
  assign scan_o.count     = count_q;
  assign scan_o.max_level = max_q;

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign popped_value_o = out_val_q;
  assign status_o       = out_st_q;

endmodule

`default_nettype wire

### hdl/max_frequency_stack_unit.sv
// ---------------------------------------------------------------------------
// max_frequency_stack_unit
// Stack of 32-bit values that pops the most frequent value first.
// ---------------------------------------------------------------------------
// A push stores its value with a level one above the number of live equal
// entries; a pop returns the newest entry at the highest level and closes
// the gap. A command that scans sends a scan token along the row of live
// entry cells one cell per cycle, then commits. A pop on an empty stack
// returns 0 with status 1, a push on a full stack is refused with status 2;
// neither scans. One result per command, held in an output register until
// transferred; while it waits, the next command may be taken and scanned
// but does not commit.
`default_nettype none

module max_frequency_stack_unit import mfs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              cmd_i,
  input  logic signed [31:0] push_value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic signed [31:0] popped_value_o,
  output logic [1:0]        status_o
);

  token_t  tok     [Depth];
  token_t  tok_in  [Depth];
  val_t    value   [Depth];
  lvl_t    level   [Depth];
  val_t    nxt_val [Depth];
  lvl_t    nxt_lvl [Depth];
  scan_t   scan;
  upd_t    upd;
  idx_t    pos;
  idx_t    last_idx;
  token_t  tok_sel;
  val_t    pop_val;
  status_e status;

  // Token leaving the newest live cell, and the entry being removed
  assign last_idx = idx_t'(scan.count - cnt_t'(1));
  assign tok_sel  = tok[last_idx];
  assign pop_val  = value[pos];

  mfs_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .push_value_i   (push_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .popped_value_o (popped_value_o),
    .status_o       (status),
    .tok_sel_i      (tok_sel),
    .pop_val_i      (pop_val),
    .scan_o         (scan),
    .upd_o          (upd),
    .pos_o          (pos)
  );

  assign status_o = status;

  // Row of entry cells, oldest at index zero
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign tok_in[g] = '0;
    end else begin : g_body
      assign tok_in[g] = tok[g-1];
    end

    if (g == Depth - 1) begin : g_top
      assign nxt_val[g] = value[g];
      assign nxt_lvl[g] = level[g];
    end else begin : g_mid
      assign nxt_val[g] = value[g+1];
      assign nxt_lvl[g] = level[g+1];
    end

    mfs_cell u_cell (
      .clk_i        (clk_i),
      .cell_idx_i   (idx_t'(g)),
      .scan_i       (scan),
      .tok_i        (tok_in[g]),
      .tok_o        (tok[g]),
      .upd_i        (upd),
      .next_value_i (nxt_val[g]),
      .next_level_i (nxt_lvl[g]),
      .value_o      (value[g]),
      .level_o      (level[g])
    );
  end

endmodule

`default_nettype wire

### hdl/mfs_checker.sv
// ---------------------------------------------------------------------------
// mfs_checker
// Port-level assertions for the maximum-frequency stack, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mfs_checker import mfs_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic signed [31:0] popped_value_o,
  input logic [1:0]        status_o
);

  logic        in_xfer;
  logic        res_held;
  logic        res_has_val;
  logic [33:0] res_bits;

  // Handshake and payload views
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign res_held    = out_valid_o && out_stall_i;
  assign res_has_val = out_valid_o && (popped_value_o != '0);
  assign res_bits    = {popped_value_o, status_o};

  // A stalled result holds
  `MFS_ASSERT(a_out_hold, res_held |=> out_valid_o && $stable(res_bits), "stalled result moved")

  // One command in flight: a transfer closes the input
  `MFS_ASSERT(a_one_in_flight, in_xfer |=> in_stall_o, "input open after transfer")

  // Only a successful pop carries a value
  `MFS_ASSERT(a_value_ok, res_has_val |-> status_o == STATUS_OK, "value on a refused command")

endmodule

bind max_frequency_stack_unit mfs_checker u_mfs_checker (.*);

`default_nettype wire
